/* hw/rtl/u8d_pkg.sv */
package u8d_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_ERROR      = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_t;

  // Queue between classifier and decoder
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  localparam int CpW   = 31;
  localparam int CntW  = 3;
  localparam int OutW  = 40;

  // One classified byte
  typedef struct packed {
    logic            is_cont;   // 0x80-0xBF
    logic            bad_lead;  // 0x80-0xBF, 0xFE, 0xFF
    logic [CntW-1:0] len;       // continuation bytes a lead byte announces
    logic [6:0]      payload;   // lead byte minus marker, or low six bits
    logic            last;      // end of input on this byte
  } entry_t;

endpackage

/* hw/rtl/utf8_byte_stream_decoder.sv */
// A byte that completes a result is written into the queue and shows on m_tvalid from the
// output register once the bytes queued ahead of it have been decoded.
// Throughput: one byte per cycle unless the output stalls; one state update per byte sets it.
// A 4-entry queue lets input acceptance continue while the output is stalled.
// Reset (rst, synchronous, active high) empties the queue, drops the output request
// and returns the decoder to idle with a cleared accumulator.
module utf8_byte_stream_decoder
  import u8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // [7:0] data_byte
  input  logic            s_tlast,   // end_of_input
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [OutW-1:0] m_tdata    // [30:0] code_point, [32:31] status, [35:33] pending_bytes
);

  logic   q_full;
  logic   push;
  entry_t wr_entry;
  logic   pop;
  logic   q_valid;
  entry_t q_entry;

  u8d_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .entry    (wr_entry)
  );

  u8d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_entry (q_entry)
  );

  u8d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* hw/rtl/u8d_front.sv */
module u8d_front
  import u8d_pkg::*;
(
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_input
  input  logic       q_full,
  output logic       push,
  output entry_t     entry
);

  logic [7:0] b;

  assign b        = s_tdata;
  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  // Classify the byte on its own; sequence state lives in the back part
  always_comb begin
    entry          = '0;
    entry.last     = s_tlast;
    entry.is_cont  = (b[7:6] == 2'b10);
    entry.bad_lead = (b[7:6] == 2'b10) || (b[7:1] == 7'b1111111);
    if (!b[7]) begin
      entry.len     = 3'd0;
      entry.payload = b[6:0];
    end else if (!b[5]) begin
      entry.len     = 3'd1;
      entry.payload = {2'b00, b[4:0]};
    end else if (!b[4]) begin
      entry.len     = 3'd2;
      entry.payload = {3'b000, b[3:0]};
    end else if (!b[3]) begin
      entry.len     = 3'd3;
      entry.payload = {4'b0000, b[2:0]};
    end else if (!b[2]) begin
      entry.len     = 3'd4;
      entry.payload = {5'b00000, b[1:0]};
    end else begin
      entry.len     = 3'd5;
      entry.payload = {6'b000000, b[0]};
    end
    // Continuation bytes (0x80-0xBF) carry their low six bits
    if (b[7:6] == 2'b10) begin
      entry.payload = {1'b0, b[5:0]};
    end
  end

endmodule

/* hw/rtl/u8d_queue.sv */
module u8d_queue
  import u8d_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  output logic   full,
  input  logic   pop,
  output logic   rd_valid,
  output entry_t rd_entry
);

  entry_t         mem [QDepth];
  logic [QAw-1:0] wr_ptr;
  logic [QAw-1:0] rd_ptr;
  logic [QAw:0]   count;

  assign full     = (count == (QAw+1)'(QDepth));
  assign rd_valid = (count != '0);
  assign rd_entry = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/u8d_back.sv */
module u8d_back
  import u8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  entry_t          q_entry,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [OutW-1:0] m_tdata   // [30:0] code_point, [32:31] status, [35:33] pending_bytes
);

  logic [CpW-1:0]  acc;
  logic [CntW-1:0] rem;
  logic [CntW-1:0] taken;
  logic [CpW-1:0]  acc_next;
  logic [CntW-1:0] rem_next;
  logic [CntW-1:0] taken_next;

  logic            emit;
  logic [CpW-1:0]  cp;
  status_t         st;
  logic [CntW-1:0] pend;
  logic [CpW-1:0]  shifted;

  logic [CpW-1:0]  out_cp;
  status_t         out_st;
  logic [CntW-1:0] out_pend;

  assign pop     = q_valid && (!m_tvalid || m_tready);
  assign shifted = {acc[CpW-7:0], q_entry.payload[5:0]};
  assign m_tdata = {(OutW-CpW-2-CntW)'(0), out_pend, out_st, out_cp};

  // Sequence update for one byte
  always_comb begin
    acc_next   = acc;
    rem_next   = rem;
    taken_next = taken;
    emit       = 1'b0;
    cp         = '0;
    st         = ST_DONE;
    pend       = '0;
    if (rem == '0) begin
      if (q_entry.bad_lead) begin
        emit = 1'b1;
        st   = ST_ERROR;
      end else if (q_entry.len == '0) begin
        emit = 1'b1;
        cp   = CpW'(q_entry.payload);
      end else if (q_entry.last) begin
        emit = 1'b1;
        st   = ST_INCOMPLETE;
        pend = 3'd1;
        acc_next = '0;
      end else begin
        acc_next   = CpW'(q_entry.payload);
        rem_next   = q_entry.len;
        taken_next = 3'd1;
      end
    end else begin
      if (!q_entry.is_cont) begin
        emit = 1'b1;
        st   = ST_ERROR;
      end else if (rem == 3'd1) begin
        emit = 1'b1;
        cp   = shifted;
      end else if (q_entry.last) begin
        emit = 1'b1;
        st   = ST_INCOMPLETE;
        pend = taken + 1'b1;
      end else begin
        acc_next   = shifted;
        rem_next   = rem - 1'b1;
        taken_next = taken + 1'b1;
      end
      if (emit) begin
        acc_next   = '0;
        rem_next   = '0;
        taken_next = '0;
      end
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      rem   <= '0;
      taken <= '0;
    end else if (pop) begin
      acc   <= acc_next;
      rem   <= rem_next;
      taken <= taken_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_cp   <= cp;
      out_st   <= st;
      out_pend <= pend;
    end
  end

endmodule
